@@ sv/kcd_pkg.sv @@
package kcd_pkg;

   // Sizes of the entry buffer and of the chord slot row.
   localparam int BUFFER_DEPTH   = 16;
   localparam int MAX_CHORD_KEYS = 4;
   localparam int KEY_REGS       = 4;

   localparam int KEY_W       = 9;
   localparam int CHORD_W     = 16;
   localparam int WINDOW_W    = 16;
   localparam int KCNT_W      = 3;
   localparam int COUNT_W     = $clog2(BUFFER_DEPTH + 1);
   localparam int IDX_W       = $clog2(BUFFER_DEPTH);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CHORD_W-1:0]  CHORD_NUMBER_RESET = 16'd1;
   localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RESET = 16'd50;
   localparam logic [KCNT_W-1:0]   KEY_COUNT_RESET    = 3'd1;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] REG_CHORD_NUMBER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_COUNT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHORD_KEY_A  = 3'd3;

   // One buffered key event; mark flags an entry claimed by the chord.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             down;
      logic             mark;
   } entry_type;

   typedef struct packed {
      logic                                 shift;
      logic                                 load;
   } cell_ctrl_type;

   typedef struct packed {
      logic [CHORD_W-1:0]                   chord_number;
      logic [WINDOW_W-1:0]                  window_ticks;
      logic [MAX_CHORD_KEYS-1:0]            active;
      logic [MAX_CHORD_KEYS-1:0]            needed;
      logic [MAX_CHORD_KEYS-1:0][KEY_W-1:0] slot_key;
   } cfg_type;

endpackage

@@ sv/kcd_cell.sv @@
module kcd_cell
   import kcd_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     load_entry,
   input  entry_type     next_entry,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // A load takes priority over the shift from the right-hand neighbour.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/kcd_cfg.sv @@
module kcd_cfg
   import kcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   logic [CHORD_W-1:0]             chord_number_ff;
   logic [WINDOW_W-1:0]            window_ticks_ff;
   logic [KCNT_W-1:0]              key_count_ff;
   logic [KEY_REGS-1:0][KEY_W-1:0] chord_key_ff;
   logic [MAX_CHORD_KEYS-1:0][KEY_W-1:0] slot_key;
   logic [MAX_CHORD_KEYS-1:0]      active;
   logic [MAX_CHORD_KEYS-1:0]      needed;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chord_number_ff <= CHORD_NUMBER_RESET;
         window_ticks_ff <= WINDOW_TICKS_RESET;
         key_count_ff    <= KEY_COUNT_RESET;
         chord_key_ff    <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_CHORD_NUMBER) begin
            chord_number_ff <= csr_data[CHORD_W-1:0];
         end
         if (csr_index == REG_WINDOW_TICKS) begin
            window_ticks_ff <= csr_data[WINDOW_W-1:0];
         end
         if (csr_index == REG_KEY_COUNT) begin
            key_count_ff <= csr_data[KCNT_W-1:0];
         end
         for (int k = 0; k < KEY_REGS; k++) begin
            if (csr_index == REG_CHORD_KEY_A + CSR_INDEX_W'(k)) begin
               chord_key_ff[k] <= csr_data[KEY_W-1:0];
            end
         end
      end
   end

   // Slots without a register of their own hold scancode zero.
   for (genvar i = 0; i < MAX_CHORD_KEYS; i++) begin : g_slot
      if (i < KEY_REGS) begin : g_reg
         assign slot_key[i] = chord_key_ff[i];
      end else begin : g_zero
         assign slot_key[i] = '0;
      end
   end

   // A slot is needed when it is in use and no earlier slot has the same key.
   always_comb begin
      for (int i = 0; i < MAX_CHORD_KEYS; i++) begin
         active[i] = int'(key_count_ff) > i;
         needed[i] = active[i];
         for (int j = 0; j < MAX_CHORD_KEYS; j++) begin
            if (j < i && slot_key[j] == slot_key[i]) begin
               needed[i] = 1'b0;
            end
         end
      end
   end

   assign cfg.chord_number = chord_number_ff;
   assign cfg.window_ticks = window_ticks_ff;
   assign cfg.active       = active;
   assign cfg.needed       = needed;
   assign cfg.slot_key     = slot_key;

endmodule

@@ sv/key_chord_detector.sv @@
// Key chord detector.
// Items arrive on the req_ stream: req_tuser is 0 for a one-millisecond tick and 1 for a
// key event, whose scancode and pressed flag travel in req_tdata. Results leave on the
// rsp_ stream as single key events (rsp_tuser 0) or one chord event (rsp_tuser 1);
// rsp_tlast marks the final result caused by an input transfer. Registers are written
// through the csr_ channel, which is always ready; the user must write them only while
// the block is idle, as the block does not enforce this. Buffered chord-key events live
// in a row of sixteen cells that shift towards the head, one cell leaving the head each
// cycle unless a flush waits on the receiver, and that row sets the order of work:
//    tick: no result, or a flush that emits every entry, one result per cycle;
//    key event: the entry is appended, then the buffered entries rotate once past the
//    chord comparators; if the chord is complete, the remaining entries are emitted
//    and then the chord event;
//    key event into a full buffer: a flush, then the entry goes in or a chord event.
// Only one input item is in work at a time; req_tready is high while the block waits.
// After reset the buffer is empty, the tick counter is zero and the registers hold
// their reset values. When the receiver stalls, the result register holds its
// transfer and the cell row waits with it; no result is lost or repeated.
module key_chord_detector
   import kcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // scan_key[8:0], is_down[9], zero pad
   input  logic                   req_tuser,  // action
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_key[8:0], out_down[9],
                                              // out_chord[25:10], zero pad
   output logic                   rsp_tuser,  // event_kind
   output logic                   rsp_tlast,  // last_of_run
   // Register write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_FLUSH, ST_CHORD} state_type;
   typedef enum logic [1:0] {MODE_TICK, MODE_FULL, MODE_CHORD} mode_type;

   cfg_type cfg;

   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [WINDOW_W-1:0]       tick_ff, tick_in;
   logic [IDX_W-1:0]          scan_ff, scan_in;
   logic [MAX_CHORD_KEYS-1:0] found_ff, found_in;
   entry_type                 pend_ff, pend_in;
   logic                      pend_chord_ff, pend_chord_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]          rsp_key_ff, rsp_key_in;
   logic                      rsp_down_ff, rsp_down_in;
   logic [CHORD_W-1:0]        rsp_chord_ff, rsp_chord_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Cell row.
   entry_type [BUFFER_DEPTH-1:0] cell_entry;
   cell_ctrl_type [BUFFER_DEPTH-1:0] cell_ctrl;
   logic                      chain_shift;
   logic                      chain_load;
   logic [IDX_W-1:0]          load_idx;
   entry_type                 load_entry;
   entry_type                 head;

   logic [KEY_W-1:0]          req_key;
   logic                      req_down;
   logic                      key_hit;
   logic                      single_need;
   logic [WINDOW_W-1:0]       tick_sat;
   logic [COUNT_W-1:0]        count_dec;
   logic [MAX_CHORD_KEYS-1:0] hit;
   logic [MAX_CHORD_KEYS-1:0] found_next;
   logic                      complete;
   logic                      out_free;
   logic                      emit;

   kcd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
      entry_type next_entry;
      if (i < BUFFER_DEPTH - 1) begin : g_mid
         assign next_entry = cell_entry[i+1];
      end else begin : g_end
         assign next_entry = '0;
      end
      assign cell_ctrl[i].shift = chain_shift;
      assign cell_ctrl[i].load  = chain_load && (load_idx == IDX_W'(i));
      kcd_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .load_entry (load_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i])
      );
   end

   assign head     = cell_entry[0];
   assign req_key  = req_tdata[KEY_W-1:0];
   assign req_down = req_tdata[KEY_W];
   assign tick_sat = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Chord slot comparisons: membership of the incoming key, and the claim of
   // the entry passing the head during the search rotation.
   always_comb begin
      key_hit = 1'b0;
      for (int i = 0; i < MAX_CHORD_KEYS; i++) begin
         if (cfg.active[i] && cfg.slot_key[i] == req_key) begin
            key_hit = 1'b1;
         end
         hit[i] = cfg.needed[i] && !found_ff[i] && head.down && head.key == cfg.slot_key[i];
      end
   end

   assign found_next  = found_ff | hit;
   assign complete    = ((found_next & cfg.needed) == cfg.needed) && (cfg.needed != '0);
   // Exactly one distinct chord key: a lone pressed key completes the chord.
   assign single_need = (cfg.needed != '0) && ((cfg.needed & (cfg.needed - 1'b1)) == '0);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      pend_chord_in = pend_chord_ff;
      chain_shift   = 1'b0;
      chain_load    = 1'b0;
      load_idx      = '0;
      load_entry    = '0;
      emit          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_down_in   = rsp_down_ff;
      rsp_chord_in  = rsp_chord_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  if (tick_sat >= cfg.window_ticks) begin
                     tick_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_FLUSH;
                        mode_in  = MODE_TICK;
                     end
                  end else begin
                     tick_in = tick_sat;
                  end
               end else if (key_hit) begin
                  if (count_ff == COUNT_W'(BUFFER_DEPTH)) begin
                     // Full buffer: empty it first, the new entry waits aside.
                     pend_in       = '{key: req_key, down: req_down, mark: 1'b0};
                     pend_chord_in = req_down && single_need;
                     state_in      = ST_FLUSH;
                     mode_in       = MODE_FULL;
                  end else begin
                     chain_load = 1'b1;
                     load_idx   = count_ff[IDX_W-1:0];
                     load_entry = '{key: req_key, down: req_down, mark: 1'b0};
                     count_in   = count_ff + 1'b1;
                     scan_in    = '0;
                     found_in   = '0;
                     state_in   = ST_SEARCH;
                  end
               end
            end
         end

         ST_SEARCH: begin
            // Rotate the row once: the head goes back in at the tail with its claim.
            chain_shift     = 1'b1;
            chain_load      = 1'b1;
            load_idx        = count_dec[IDX_W-1:0];
            load_entry      = head;
            load_entry.mark = |hit;
            found_in        = found_next;
            scan_in         = scan_ff + 1'b1;
            if (COUNT_W'(scan_ff) == count_dec) begin
               if (complete) begin
                  state_in = ST_FLUSH;
                  mode_in  = MODE_CHORD;
                  tick_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               chain_shift  = 1'b1;
               count_in     = count_dec;
               emit         = !(mode_ff == MODE_CHORD && head.mark);
               rsp_kind_in  = 1'b0;
               rsp_key_in   = head.key;
               rsp_down_in  = head.down;
               rsp_chord_in = '0;
               rsp_last_in  = (count_ff == COUNT_W'(1)) &&
                              (mode_ff == MODE_TICK || (mode_ff == MODE_FULL && !pend_chord_ff));
               if (count_ff == COUNT_W'(1)) begin
                  unique case (mode_ff)
                     MODE_TICK: begin
                        state_in = ST_IDLE;
                     end
                     MODE_FULL: begin
                        if (pend_chord_ff) begin
                           state_in = ST_CHORD;
                           tick_in  = '0;
                        end else begin
                           chain_load = 1'b1;
                           load_idx   = '0;
                           load_entry = pend_ff;
                           count_in   = COUNT_W'(1);
                           state_in   = ST_IDLE;
                        end
                     end
                     MODE_CHORD: begin
                        state_in = ST_CHORD;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end

         ST_CHORD: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_key_in   = '0;
               rsp_down_in  = 1'b1;
               rsp_chord_in = cfg.chord_number;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_TICK;
         count_ff      <= '0;
         tick_ff       <= '0;
         scan_ff       <= '0;
         found_ff      <= '0;
         pend_ff       <= '0;
         pend_chord_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_kind_ff   <= 1'b0;
         rsp_key_ff    <= '0;
         rsp_down_ff   <= 1'b0;
         rsp_chord_ff  <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         scan_ff       <= scan_in;
         found_ff      <= found_in;
         pend_ff       <= pend_in;
         pend_chord_ff <= pend_chord_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (emit) begin
            rsp_kind_ff  <= rsp_kind_in;
            rsp_key_ff   <= rsp_key_in;
            rsp_down_ff  <= rsp_down_in;
            rsp_chord_ff <= rsp_chord_in;
            rsp_last_ff  <= rsp_last_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_chord_ff, rsp_down_ff, rsp_key_ff});

   // A chord event always closes the run of results of its input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("chord event without tlast");

   // The search rotation puts every entry back, so the fill count holds.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |=> count_ff == $past(count_ff))
      else $error("entry count changed during search rotation");

   // Each flush step with entries left behind removes exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && out_free && count_ff > COUNT_W'(1)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("flush step did not remove one entry");

   // After each accepted item the fill count is within the row length.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> count_ff <= COUNT_W'(BUFFER_DEPTH))
      else $error("entry count beyond buffer depth");

endmodule

@@ sim/tb_key_chord_detector.sv @@
`timescale 1ns / 1ps

// Testbench for the key chord detector.
//
// Items go in on the req_ stream and are predicted when their transfer completes.
// The prediction comes from a copy of the buffer, the tick counter and the registers
// held here. The expected results wait in a queue. Each result transfer on the rsp_
// stream is checked, field by field, against the oldest entry in that queue.
//
// The run first walks through a few hand-picked cases:
//    - reset values;
//    - a four-key chord using the extreme scancodes;
//    - a zero window;
//    - key_count of zero and above the slot count, with repeated slots;
//    - chord number zero.
// After that come random phases. Each phase has its own register settings and
// mostly carries chord presses with random content, along with releases, tick
// bursts and stray keys. The case before them fills the buffer past its depth.
//
// Registers are only rewritten after all expected results have arrived. The sender
// also waits a settling period first, since a key event that produces nothing may
// still be rotating through the cell row.
module tb_key_chord_detector;
   import kcd_pkg::*;

   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_KEY     = 1'b1;
   localparam logic KIND_SINGLE = 1'b0;
   localparam logic KIND_CHORD  = 1'b1;

   // Index 7 has no register behind it; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   // The worst case for one item is well inside this settling period.
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int TOTAL_ITEMS   = 310;
   localparam int IDLE_PERCENT  = 36;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic               kind;
      logic [KEY_W-1:0]   key;
      logic               down;
      logic [CHORD_W-1:0] chord;
      logic               ends_run;
   } chord_result_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // The predictor's view of the registers and of the buffer.
   logic [CHORD_W-1:0]  cfg_chord_number;
   logic [WINDOW_W-1:0] cfg_window;
   logic [KCNT_W-1:0]   cfg_key_count;
   logic [KEY_W-1:0]    cfg_slot_key [MAX_CHORD_KEYS];
   logic [KEY_W-1:0]    held_key [BUFFER_DEPTH];
   logic                held_down [BUFFER_DEPTH];
   int                  held_count;
   logic [15:0]         tick_count;

   chord_result_type expected_events[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   int               sent_items     = 0;
   bit               steady         = 1'b0;

   key_chord_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The watchdog ends a run that hangs, for instance when a result never appears.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[key_chord_detector] ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, except while a steady stretch is running.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
   end

   // ---------------------------------------------------------------- prediction

   function automatic void clear_prediction();
      cfg_chord_number = CHORD_NUMBER_RESET;
      cfg_window       = WINDOW_TICKS_RESET;
      cfg_key_count    = KEY_COUNT_RESET;
      foreach (cfg_slot_key[i]) cfg_slot_key[i] = '0;
      held_count = 0;
      tick_count = '0;
   endfunction

   // Appends one result to the tail of the expected queue.
   function automatic void queue_expected(chord_result_type r);
      expected_events.insert(expected_events.size(), r);
   endfunction

   // key_count values above the slot count act as the full slot count.
   function automatic int live_slots();
      return (cfg_key_count > MAX_CHORD_KEYS) ? MAX_CHORD_KEYS : int'(cfg_key_count);
   endfunction

   function automatic bit is_chord_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < live_slots(); i++)
         if (cfg_slot_key[i] == key) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void flush_held();
      chord_result_type r;
      for (int i = 0; i < held_count; i++) begin
         r.kind     = KIND_SINGLE;
         r.key      = held_key[i];
         r.down     = held_down[i];
         r.chord    = '0;
         r.ends_run = 1'b0;
         queue_expected(r);
      end
      held_count = 0;
   endfunction

   // Checks whether every distinct live chord key has a pressed entry. If so, the
   // first such entry for each key is claimed and the buffer closes up behind it.
   function automatic bit take_chord();
      bit claimed [BUFFER_DEPTH];
      bit found;
      bit seen_before;
      int n;
      int k;
      n = live_slots();
      if (n == 0) return 1'b0;
      foreach (claimed[e]) claimed[e] = 1'b0;
      for (int i = 0; i < n; i++) begin
         seen_before = 1'b0;
         for (int j = 0; j < i; j++)
            if (cfg_slot_key[j] == cfg_slot_key[i]) seen_before = 1'b1;
         if (!seen_before) begin
            found = 1'b0;
            for (int e = 0; e < held_count && !found; e++) begin
               if (held_down[e] && held_key[e] == cfg_slot_key[i]) begin
                  claimed[e] = 1'b1;
                  found      = 1'b1;
               end
            end
            if (!found) return 1'b0;
         end
      end
      k = 0;
      for (int e = 0; e < held_count; e++) begin
         if (!claimed[e]) begin
            held_key[k]  = held_key[e];
            held_down[k] = held_down[e];
            k++;
         end
      end
      held_count = k;
      return 1'b1;
   endfunction

   function automatic void predict_chord_events(logic act, logic [KEY_W-1:0] key,
                                                logic down);
      chord_result_type r;
      int               first;
      first = expected_events.size();
      if (act == ACT_TICK) begin
         if (tick_count != 16'hFFFF) tick_count++;
         if (tick_count >= cfg_window) begin
            flush_held();
            tick_count = '0;
         end
      end else if (is_chord_key(key)) begin
         // A full buffer is emptied before the new entry goes in; the tick count stays.
         if (held_count >= BUFFER_DEPTH) flush_held();
         held_key[held_count]  = key;
         held_down[held_count] = down;
         held_count++;
         if (take_chord()) begin
            flush_held();
            tick_count = '0;
            r.kind     = KIND_CHORD;
            r.key      = '0;
            r.down     = 1'b1;
            r.chord    = cfg_chord_number;
            r.ends_run = 1'b0;
            queue_expected(r);
         end
      end
      if (expected_events.size() > first)
         expected_events[expected_events.size() - 1].ends_run = 1'b1;
   endfunction

   // ------------------------------------------------------------------ checking

   always @(posedge clock) begin : check_results
      chord_result_type   want;
      logic               got_kind;
      logic [KEY_W-1:0]   got_key;
      logic               got_down;
      logic [CHORD_W-1:0] got_chord;
      logic               got_last;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_kind  = rsp_tuser;
         got_key   = rsp_tdata[KEY_W-1:0];
         got_down  = rsp_tdata[KEY_W];
         got_chord = rsp_tdata[KEY_W+1 +: CHORD_W];
         got_last  = rsp_tlast;
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: kind %0d key %0d down %0d chord %0d last %0d",
                        got_kind, got_key, got_down, got_chord, got_last);
         end else begin
            want = expected_events.pop_front();
            if (got_kind !== want.kind || got_key !== want.key || got_down !== want.down ||
                got_chord !== want.chord || got_last !== want.ends_run) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result mismatch at cycle %0d:", cycle_count);
                  $display("   expected kind %0d key %0d down %0d chord %0d last %0d",
                           want.kind, want.key, want.down, want.chord, want.ends_run);
                  $display("   actual   kind %0d key %0d down %0d chord %0d last %0d",
                           got_kind, got_key, got_down, got_chord, got_last);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------- driving

   // Sends one item and predicts it at the edge where its transfer completes. Valid
   // is left high after the transfer, so back-to-back items keep it high throughout.
   task automatic send_item(input logic act, input logic [KEY_W-1:0] key,
                            input logic down);
      if (!steady && $urandom_range(99, 0) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < IDLE_PERCENT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_W - KEY_W - 1){1'b0}}, down, key};
      do @(posedge clock); while (!req_tready);
      sent_items++;
      predict_chord_events(act, key, down);
   endtask

   // Holds back the sender until every expected result has arrived, and then lets the
   // block settle.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_CHORD_NUMBER: cfg_chord_number = value;
         REG_WINDOW_TICKS: cfg_window = value;
         REG_KEY_COUNT:    cfg_key_count = value[KCNT_W-1:0];
         REG_UNUSED:       ;
         default:          cfg_slot_key[index - REG_CHORD_KEY_A] = value[KEY_W-1:0];
      endcase
   endtask

   // Writes every register. The narrow registers get random upper bits, which the
   // block must drop, and the unused index gets a random write as well.
   task automatic apply_settings(input logic [CHORD_W-1:0] chord_no,
                                 input logic [WINDOW_W-1:0] window,
                                 input logic [KCNT_W-1:0] count,
                                 input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb,
                                 input logic [KEY_W-1:0] kc, input logic [KEY_W-1:0] kd);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(REG_CHORD_NUMBER, chord_no);
      write_reg(REG_WINDOW_TICKS, window);
      write_reg(REG_KEY_COUNT, {junk[CSR_DATA_W-KCNT_W-1:0], count});
      write_reg(REG_CHORD_KEY_A, {junk[6:0], ka});
      write_reg(REG_CHORD_KEY_A + 3'd1, {junk[13:7], kb});
      write_reg(REG_CHORD_KEY_A + 3'd2, {junk[20:14], kc});
      write_reg(REG_CHORD_KEY_A + 3'd3, {junk[27:21], kd});
      write_reg(REG_UNUSED, junk[31:16]);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] any_chord_key();
      if (live_slots() == 0) return KEY_W'($urandom_range(511, 0));
      return cfg_slot_key[$urandom_range(live_slots() - 1, 0)];
   endfunction

   // One random sequence of items. Most sequences press every chord key in a shuffled
   // order. Some of those are broken by a stray transfer or by a key left out.
   task automatic run_sequence();
      int slots;
      int pick;
      int skip;
      int len;
      int j;
      int swap;
      int order [MAX_CHORD_KEYS];
      slots = live_slots();
      pick  = $urandom_range(99, 0);
      if (pick < 55 && slots > 0) begin
         for (int i = 0; i < slots; i++) order[i] = i;
         for (int i = slots - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
         end
         skip = ($urandom_range(99, 0) < 15) ? int'($urandom_range(slots - 1, 0)) : -1;
         for (int i = 0; i < slots; i++) begin
            if ($urandom_range(99, 0) < 15) begin
               case ($urandom_range(2, 0))
                  0:       send_item(ACT_TICK, KEY_W'($urandom), 1'($urandom));
                  1:       send_item(ACT_KEY, any_chord_key(), 1'b0);
                  default: send_item(ACT_KEY, KEY_W'($urandom), 1'($urandom));
               endcase
            end
            if (i != skip) send_item(ACT_KEY, cfg_slot_key[order[i]], 1'b1);
         end
      end else if (pick < 70) begin
         len = $urandom_range(3, 1);
         repeat (len) send_item(ACT_KEY, any_chord_key(), 1'b0);
      end else if (pick < 85) begin
         // Enough ticks to reach a short window, so that the timeout flush occurs.
         len = (cfg_window < 12) ? int'(cfg_window) + 1 : int'($urandom_range(4, 1));
         repeat (len) send_item(ACT_TICK, KEY_W'($urandom), 1'($urandom));
      end else begin
         len = $urandom_range(3, 1);
         repeat (len) send_item(ACT_KEY, KEY_W'($urandom), 1'($urandom));
      end
   endtask

   // -------------------------------------------------------------------- tests

   // Reset values: one chord key, scancode 0, chord number 1, window 50.
   task automatic test_reset_defaults();
      send_item(ACT_KEY, 9'd0, 1'b1);
      send_item(ACT_KEY, 9'd511, 1'b1);
      send_item(ACT_KEY, 9'd0, 1'b0);
      send_item(ACT_TICK, 9'd0, 1'b0);
   endtask

   // A four-key chord using the lowest and highest scancodes. A released entry
   // survives the chord, and a later entry is flushed when the window expires.
   task automatic test_four_key_chord();
      wait_for_quiet();
      apply_settings(16'hFFFF, 16'd3, 3'd4, 9'd0, 9'd511, 9'd256, 9'd1);
      send_item(ACT_KEY, 9'd511, 1'b1);
      send_item(ACT_KEY, 9'd0, 1'b0);
      send_item(ACT_KEY, 9'd0, 1'b1);
      send_item(ACT_KEY, 9'd256, 1'b1);
      send_item(ACT_KEY, 9'd1, 1'b1);
      send_item(ACT_KEY, 9'd256, 1'b0);
      repeat (3) send_item(ACT_TICK, 9'd511, 1'b1);
   endtask

   // With a zero window every tick flushes, including a tick on an empty buffer.
   task automatic test_zero_window();
      wait_for_quiet();
      apply_settings(16'h8000, 16'd0, 3'd2, 9'd7, 9'd8, 9'd7, 9'd8);
      send_item(ACT_KEY, 9'd7, 1'b1);
      send_item(ACT_TICK, 9'd0, 1'b0);
      send_item(ACT_TICK, 9'd0, 1'b0);
   endtask

   // A key_count of zero ignores every key. A count above the slot count uses all
   // four slots, and a repeated scancode is needed only once. The chord number is 0.
   task automatic test_slot_edges();
      wait_for_quiet();
      apply_settings(16'h1234, 16'hFFFF, 3'd0, 9'd0, 9'd0, 9'd0, 9'd0);
      send_item(ACT_KEY, 9'd0, 1'b1);
      wait_for_quiet();
      apply_settings(16'h0000, 16'hFFFF, 3'd7, 9'd10, 9'd10, 9'd10, 9'd20);
      send_item(ACT_KEY, 9'd10, 1'b1);
      send_item(ACT_KEY, 9'd20, 1'b1);
      send_item(ACT_KEY, 9'd20, 1'b0);
   endtask

   // Releases fill the buffer past its depth, so the first entry beyond the depth
   // empties the buffer. A chord pressed afterwards flushes whatever is left.
   task automatic test_full_buffer();
      logic [KEY_W-1:0] base;
      int               len;
      base = KEY_W'($urandom_range(511, 0));
      len  = BUFFER_DEPTH + 1 + $urandom_range(3, 0);
      wait_for_quiet();
      apply_settings(CHORD_W'($urandom), 16'hFFFF, 3'd2, base, base ^ 9'h155, base, base);
      repeat (len) send_item(ACT_KEY, any_chord_key(), 1'b0);
      send_item(ACT_TICK, KEY_W'($urandom), 1'($urandom));
      send_item(ACT_KEY, base, 1'b1);
      send_item(ACT_KEY, base ^ 9'h155, 1'b1);
   endtask

   // Random phases, each with fresh register settings, until the item total is
   // reached. Mostly the chord keys are distinct; now and then the slots repeat a
   // scancode, the count is out of range, or the window is at an extreme. The third
   // phase runs with no idling on either side.
   task automatic test_random_traffic();
      int                  phase;
      int                  r;
      logic [KEY_W-1:0]    base;
      logic [KEY_W-1:0]    stride;
      logic [KEY_W-1:0]    keys [KEY_REGS];
      logic [WINDOW_W-1:0] window;
      logic [KCNT_W-1:0]   count;
      phase = 0;
      while (sent_items < TOTAL_ITEMS) begin
         r = $urandom_range(99, 0);
         if (r < 6)        count = 3'd0;
         else if (r < 14)  count = KCNT_W'($urandom_range(7, 5));
         else              count = KCNT_W'($urandom_range(4, 1));
         r = $urandom_range(99, 0);
         if (r < 8)        window = 16'd0;
         else if (r < 14)  window = 16'hFFFF;
         else if (r < 20)  window = 16'd1;
         else              window = WINDOW_W'($urandom_range(12, 2));
         base   = KEY_W'($urandom_range(511, 0));
         stride = KEY_W'($urandom_range(127, 1));
         r      = $urandom_range(99, 0);
         for (int i = 0; i < KEY_REGS; i++) begin
            if (r < 75) keys[i] = base + KEY_W'(i) * stride;
            else        keys[i] = $urandom_range(1, 0) ? base : base + stride;
         end
         wait_for_quiet();
         steady = (phase == 2);
         apply_settings(CHORD_W'($urandom), window, count, keys[0], keys[1], keys[2],
                        keys[3]);
         repeat (steady ? 16 : 8) run_sequence();
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      clear_prediction();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_four_key_chord();
      test_zero_window();
      test_slot_edges();
      test_full_buffer();
      test_random_traffic();

      wait_for_quiet();
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("[key_chord_detector] OK");
      end else begin
         $display("[key_chord_detector] ERROR");
      end
      $finish;
   end

endmodule
